// ----- design/kch_pkg.sv -----
// ----------------------------------------------------------------------------
// kch_pkg: shared definitions for the k-mer count histogram
// Sizes, opcodes, controller states and the character helpers used by the
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package kch_pkg;

   // Longest counted k-mer in bases, and the table index width it implies.
   localparam int MAX_WORD    = 8;
   localparam int TABLE_BITS  = 2 * MAX_WORD;
   localparam int TABLE_DEPTH = 1 << TABLE_BITS;
   localparam int COUNT_BITS  = 32;
   localparam int WS_BITS     = 4;
   localparam int RUN_BITS    = $clog2(MAX_WORD + 1);
   localparam int SHIFT_BITS  = $clog2(TABLE_BITS + 1);

   localparam logic [WS_BITS-1:0]  WS_RESET  = WS_BITS'(5);
   localparam logic [7:0]          CHAR_LF   = 8'h0A;
   localparam logic [1:0]          PHASE_SEQ = 2'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      OP_BYTE     = 2'd0,
      OP_NEW_FILE = 2'd1,
      OP_QUERY    = 2'd2
   } kch_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_HOLD
   } kch_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_we;
      logic incr_we;
      logic rsp_load;
   } kch_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic needs_lookup;
      logic pend_query;
      logic rsp_busy;
   } kch_stat_type;

   // Base code of a character: bit 2 marks a valid base, bits 1:0 the code.
   function automatic logic [2:0] base_code(input logic [7:0] chr);
      logic [7:0] up;
      logic [2:0] res;
      up = chr;
      if (chr inside {[8'h61:8'h7A]}) begin
         up = chr - 8'd32;
      end
      case (up)
         8'h41:   res = 3'b100;
         8'h43:   res = 3'b101;
         8'h47:   res = 3'b110;
         8'h54:   res = 3'b111;
         default: res = 3'b000;
      endcase
      return res;
   endfunction

   // Mask keeping the low 2k bits of a table index.
   function automatic logic [TABLE_BITS-1:0] word_mask(input logic [WS_BITS-1:0] k);
      logic [SHIFT_BITS-1:0] sh;
      sh = SHIFT_BITS'({k, 1'b0});
      return ~({TABLE_BITS{1'b1}} << sh);
   endfunction

endpackage
`default_nettype wire

// ----- design/kch_ram.sv -----
// ----------------------------------------------------------------------------
// kch_ram: generic two-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module kch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/kch_ctrl.sv -----
// ----------------------------------------------------------------------------
// kch_ctrl: controller of the k-mer count histogram
// Sequences the table clearing pass, request intake, count write-back and
// result hand-over.
// ----------------------------------------------------------------------------
`default_nettype none
module kch_ctrl
   import kch_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire kch_stat_type stat,
   output kch_cmd_type       cmd
);

   kch_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && stat.needs_lookup) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.pend_query && stat.rsp_busy) state_in = ST_HOLD;
            else state_in = ST_IDLE;
         end
         ST_HOLD: begin
            if (!stat.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOOKUP: begin
            cmd.incr_we  = !stat.pend_query;
            cmd.rsp_load = stat.pend_query && !stat.rsp_busy;
         end
         ST_HOLD: begin
            cmd.rsp_load = !stat.rsp_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/kch_dpath.sv -----
// ----------------------------------------------------------------------------
// kch_dpath: datapath of the k-mer count histogram
// Line phase, base window and run tracking, the count table and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none
module kch_dpath
   import kch_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            req_tuser,
   input  wire logic [23:0]           req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [COUNT_BITS-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [WS_BITS-1:0]    csr_data,
   input  wire kch_cmd_type           cmd,
   output kch_stat_type               stat
);

   logic [WS_BITS-1:0]    ws_ff;
   logic [1:0]            phase_ff, phase_in;
   logic [TABLE_BITS-1:0] window_ff, window_in, window_shift;
   logic [RUN_BITS-1:0]   run_ff, run_in, run_inc;
   logic [TABLE_BITS-1:0] clr_ff;
   logic [TABLE_BITS-1:0] addr_ff, lookup_addr, mask;
   logic                  pend_query_ff, in_range_ff, in_range;
   logic                  rsp_valid_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_sat_ff;
   logic [WS_BITS-1:0]    eff_k;
   logic [7:0]            data_byte;
   logic [TABLE_BITS-1:0] kmer_index;
   logic [2:0]            code;
   logic                  counted;
   kch_op_type            op;
   logic                  ram_we;
   logic [TABLE_BITS-1:0] ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

   assign op         = kch_op_type'(req_tuser);
   assign data_byte  = req_tdata[7:0];
   assign kmer_index = req_tdata[23:8];

   // Word size register and its clamped value.
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= WS_RESET;
      end else if (csr_valid && csr_ready) begin
         ws_ff <= csr_data;
      end
   end

   always_comb begin
      if (ws_ff == '0) eff_k = WS_BITS'(1);
      else if (ws_ff > WS_BITS'(MAX_WORD)) eff_k = WS_BITS'(MAX_WORD);
      else eff_k = ws_ff;
   end

   assign mask     = word_mask(eff_k);
   assign in_range = (kmer_index & ~mask) == '0;
   assign code     = base_code(data_byte);
   assign window_shift = {window_ff[TABLE_BITS-3:0], code[1:0]};
   assign run_inc  = (run_ff < RUN_BITS'(MAX_WORD)) ? run_ff + RUN_BITS'(1) : run_ff;

   // Effect of the offered request on the line and run state.
   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      run_in      = run_ff;
      lookup_addr = kmer_index;
      counted     = 1'b0;
      case (op)
         OP_BYTE: begin
            if (data_byte == CHAR_LF) begin
               phase_in = phase_ff + 2'd1;
               run_in   = '0;
            end else if (phase_ff == PHASE_SEQ) begin
               if (!code[2]) begin
                  run_in = '0;
               end else begin
                  window_in   = window_shift;
                  run_in      = run_inc;
                  counted     = RUN_BITS'(eff_k) <= run_inc;
                  lookup_addr = window_shift & mask;
               end
            end
         end
         OP_NEW_FILE: begin
            phase_in  = '0;
            window_in = '0;
            run_in    = '0;
         end
         OP_QUERY: begin
            lookup_addr = kmer_index;
         end
         default: begin
            counted = 1'b0;
         end
      endcase
   end

   // Line state, updated when a word is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         window_ff <= '0;
         run_ff    <= '0;
      end else if (cmd.accept) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         run_ff    <= run_in;
      end
   end

   // Details of the pending table access.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_query_ff <= 1'b0;
      end else if (cmd.accept) begin
         pend_query_ff <= op == OP_QUERY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff     <= lookup_addr;
         in_range_ff <= in_range;
      end
   end

   // Clearing pass address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_ff <= clr_ff + TABLE_BITS'(1);
      end
   end

   // Count table: cleared, then incremented with saturation.
   assign ram_we    = cmd.clear_we || cmd.incr_we;
   assign ram_waddr = cmd.clear_we ? clr_ff : addr_ff;
   assign ram_wdata = cmd.clear_we ? '0 :
                      (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

   kch_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept && stat.needs_lookup),
      .rd_addr (lookup_addr),
      .rd_data (ram_rdata)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_count_ff <= in_range_ff ? ram_rdata : '0;
         rsp_sat_ff   <= in_range_ff && (ram_rdata == COUNT_MAX);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // Status to the controller.
   assign stat.clear_done   = clr_ff == {TABLE_BITS{1'b1}};
   assign stat.needs_lookup = (op == OP_QUERY) || counted;
   assign stat.pend_query   = pend_query_ff;
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_tready;

endmodule
`default_nettype wire

// ----- design/kmer_count_histogram_top.sv -----
// ----------------------------------------------------------------------------
// kmer_count_histogram_top: k-mer counter for FASTQ byte streams
// Counts k-mers on the sequence line of each record and answers count queries.
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-entry count table, one entry a
// cycle, and takes no request words until that pass is done; the word size
// register may be written at any time. A stream byte that does not complete
// a k-mer, and a new-file word, need no table access. A byte that completes a
// k-mer and a query read the table memory in the cycle the word is accepted;
// the count is written back in the next. A query result waits in an output
// register, so further words are taken while it is unread; a second query
// stalls only until the first result has been taken.
`default_nettype none
module kmer_count_histogram_top
   import kch_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,   // data_byte[7:0], kmer_index[23:8]
   input  wire logic [1:0]             req_tuser,   // opcode[1:0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [COUNT_BITS-1:0]       rsp_tdata,   // count[31:0]
   output logic                        rsp_tuser,   // saturated[0]
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [WS_BITS-1:0]     csr_data
);

   kch_cmd_type  cmd;
   kch_stat_type stat;

   assign csr_ready = 1'b1;

   kch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kch_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

   // No request word is taken during the clearing pass.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> !req_tready)
      else $error("request taken during clearing pass");

   // A result is never loaded over one that has not been taken.
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // Table writes and result loads never coincide with each other.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_we, cmd.incr_we, cmd.rsp_load}))
      else $error("conflicting datapath commands");

   // A write-back always follows a table read issued by an accepted byte.
   a_incr_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.incr_we |-> $past(cmd.accept && stat.needs_lookup))
      else $error("count write-back without a preceding read");

endmodule
`default_nettype wire

// ----- tb/tb_kmer_count_histogram_top.sv -----
// ----------------------------------------------------------------------------
// tb_kmer_count_histogram_top: self-checking bench for the k-mer counter
// Streams FASTQ-shaped words into the block, mirrors the count table and
// the line tracking in a local model, and checks every query answer in
// order. Both stream sides stall at random. The word size is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_kmer_count_histogram_top;
   import kch_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         PERIOD    = 20;
   localparam int         SETTLE    = 4;

   typedef struct packed {
      logic [COUNT_BITS-1:0] cnt;
      logic                  sat;
   } kmer_reply_type;

   typedef struct {
      logic [1:0]     op;
      logic [7:0]     chr;
      logic [15:0]    qidx;
      bit             typed;
      kmer_reply_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [COUNT_BITS-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WS_BITS-1:0]    csr_data;

   // Local copy of the block state.
   logic [WS_BITS-1:0]    ws_reg;
   logic [1:0]            line_ph;
   logic [15:0]           base_win;
   logic [3:0]            run_len;
   logic [COUNT_BITS-1:0] kmer_tally [TABLE_DEPTH];
   logic [15:0]           recent_slots [$];
   kmer_reply_type        expected_counts [$];

   int words_sent = 0;
   int fail_count = 0;
   bit calm       = 1'b0;

   kmer_count_histogram_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #(PERIOD / 2) clock = 1'b1;
      #(PERIOD / 2) clock = 1'b0;
   end

   // Directed words; answers are typed in where they are obvious.
   stim_row_type steer_rows [24] = '{
      '{OP_QUERY,    8'h00,   16'h0000, 1'b1, '{32'd0, 1'b0}},
      '{OP_QUERY,    8'h00,   16'hFFFF, 1'b1, '{32'd0, 1'b0}},
      '{OP_BYTE,     CHAR_LF, 16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "A",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "C",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "G",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "T",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "a",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_QUERY,    8'h00,   16'h006C, 1'b1, '{32'd1, 1'b0}},
      '{OP_BYTE,     "N",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     8'hFF,   16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     CHAR_LF, 16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "A",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_UNUSED,   8'hFF,   16'hFFFF, 1'b0, '{32'd0, 1'b0}},
      '{OP_NEW_FILE, 8'h00,   16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     CHAR_LF, 16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "t",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "T",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "T",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "T",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_BYTE,     "T",     16'h0000, 1'b0, '{32'd0, 1'b0}},
      '{OP_QUERY,    8'h00,   16'h03FF, 1'b0, '{32'd0, 1'b0}},
      '{OP_QUERY,    8'h00,   16'h0400, 1'b1, '{32'd0, 1'b0}},
      '{OP_BYTE,     8'h00,   16'h0000, 1'b0, '{32'd0, 1'b0}}
   };

   // Word sizes for the random phases, extremes and out-of-range values included.
   logic [WS_BITS-1:0] ws_plan [8] = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd12, 4'd6, 4'd2};

   // Effective word length after clamping the register.
   function automatic int word_len();
      if (ws_reg == 0) begin
         return 1;
      end
      if (ws_reg > MAX_WORD) begin
         return MAX_WORD;
      end
      return int'(ws_reg);
   endfunction

   function automatic logic [15:0] window_mask(input int k);
      return 16'((32'd1 << (2 * k)) - 32'd1);
   endfunction

   // Applies one accepted word to the local state; returns 1 with the answer
   // when the word is a query.
   function automatic bit apply_to_tally(input logic [1:0] op, input logic [7:0] chr,
                                         input logic [15:0] qidx, output kmer_reply_type ans);
      logic [7:0]  up;
      logic [1:0]  code;
      bit          is_base;
      int          k;
      logic [15:0] slot;
      ans = '0;
      case (op)
         OP_BYTE: begin
            if (chr == CHAR_LF) begin
               line_ph = line_ph + 2'd1;
               run_len = '0;
            end else if (line_ph == PHASE_SEQ) begin
               up = (chr >= "a" && chr <= "z") ? chr - 8'd32 : chr;
               is_base = 1'b1;
               code = 2'd0;
               case (up)
                  "A":     code = 2'd0;
                  "C":     code = 2'd1;
                  "G":     code = 2'd2;
                  "T":     code = 2'd3;
                  default: is_base = 1'b0;
               endcase
               if (!is_base) begin
                  run_len = '0;
               end else begin
                  base_win = {base_win[13:0], code};
                  if (run_len < MAX_WORD) begin
                     run_len = run_len + 4'd1;
                  end
                  k = word_len();
                  if (int'(run_len) >= k) begin
                     slot = base_win & window_mask(k);
                     if (kmer_tally[slot] != COUNT_MAX) begin
                        kmer_tally[slot] = kmer_tally[slot] + 1'b1;
                     end
                     recent_slots.push_back(slot);
                     if (recent_slots.size() > 32) begin
                        void'(recent_slots.pop_front());
                     end
                  end
               end
            end
            return 1'b0;
         end
         OP_NEW_FILE: begin
            line_ph  = '0;
            base_win = '0;
            run_len  = '0;
            return 1'b0;
         end
         OP_QUERY: begin
            if ((qidx & ~window_mask(word_len())) == 16'h0000) begin
               ans.cnt = kmer_tally[qidx];
               ans.sat = (ans.cnt == COUNT_MAX);
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   // Offers one request word and waits until it is taken.
   task automatic send_word(input logic [1:0] op, input logic [7:0] chr, input logic [15:0] qidx,
                            input bit typed = 1'b0, input kmer_reply_type want = '0);
      kmer_reply_type ans;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {qidx, chr};
      req_tuser  = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (apply_to_tally(op, chr, qidx, ans)) begin
         expected_counts.push_back(typed ? want : ans);
      end
      if (op != OP_UNUSED) begin
         words_sent++;
      end
   endtask

   // Lets the block drain, then writes the word size register.
   task automatic set_word_size(input logic [WS_BITS-1:0] value);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      ws_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_base();
      if ($urandom_range(11) == 0) begin
         return 8'($urandom_range(255));
      end
      case ($urandom_range(7))
         0: return "A";
         1: return "C";
         2: return "G";
         3: return "T";
         4: return "a";
         5: return "c";
         6: return "g";
         default: return "t";
      endcase
   endfunction

   function automatic logic [15:0] pick_query();
      int r;
      r = $urandom_range(3);
      if (r <= 1 && recent_slots.size() != 0) begin
         return recent_slots[$urandom_range(recent_slots.size() - 1)];
      end
      if (r == 2) begin
         return 16'($urandom) & window_mask(word_len());
      end
      return 16'($urandom);
   endfunction

   // One four-line record with random content; now and then a line break is lost.
   task automatic emit_record();
      send_word(OP_BYTE, "@", 16'($urandom));
      repeat ($urandom_range(2)) send_word(OP_BYTE, 8'($urandom_range(33, 126)), 16'h0000);
      send_word(OP_BYTE, CHAR_LF, 16'h0000);
      repeat ($urandom_range(12)) send_word(OP_BYTE, pick_base(), 16'($urandom));
      if ($urandom_range(19) != 0) begin
         send_word(OP_BYTE, CHAR_LF, 16'h0000);
      end
      send_word(OP_BYTE, "+", 16'h0000);
      send_word(OP_BYTE, CHAR_LF, 16'h0000);
      repeat ($urandom_range(1, 3)) send_word(OP_BYTE, 8'($urandom_range(33, 126)), 16'h0000);
      send_word(OP_BYTE, CHAR_LF, 16'h0000);
   endtask

   // Result side: random back-pressure.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 15);
   end

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      kmer_reply_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_counts.size() == 0) begin
            note_fail("unexpected result word, count", 32'h0, rsp_tdata);
         end else begin
            exp_ans = expected_counts.pop_front();
            if (rsp_tdata !== exp_ans.cnt) begin
               note_fail("count", exp_ans.cnt, rsp_tdata);
            end
            if (rsp_tuser !== exp_ans.sat) begin
               note_fail("saturated", 32'(exp_ans.sat), 32'(rsp_tuser));
            end
         end
      end
   end

   // Run limit: covers the table clear after reset and a slow, stalled run.
   initial begin
      #(PERIOD * 400000);
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence.
   initial begin
      int target;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_BYTE;
      csr_valid  = 1'b0;
      csr_data   = '0;
      ws_reg     = WS_RESET;
      line_ph    = '0;
      base_win   = '0;
      run_len    = '0;
      foreach (kmer_tally[i]) kmer_tally[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset word size.
      foreach (steer_rows[i]) begin
         send_word(steer_rows[i].op, steer_rows[i].chr, steer_rows[i].qidx,
                   steer_rows[i].typed, steer_rows[i].want);
      end

      // Random phases, each at its own word size; one phase runs without stalls.
      foreach (ws_plan[p]) begin
         set_word_size(ws_plan[p]);
         calm   = (p == 4);
         target = words_sent + 46;
         while (words_sent < target) begin
            if (line_ph != 2'd0 || $urandom_range(9) == 0) begin
               send_word(OP_NEW_FILE, 8'($urandom), 16'($urandom));
            end
            emit_record();
            repeat ($urandom_range(1, 4)) send_word(OP_QUERY, 8'($urandom), pick_query());
            case ($urandom_range(19))
               0: send_word(OP_BYTE, 8'($urandom), 16'($urandom));
               1: send_word(OP_UNUSED, 8'($urandom), 16'($urandom));
               2: send_word(OP_BYTE, CHAR_LF, 16'h0000);
               default: ;
            endcase
         end
      end
      calm = 1'b0;

      // Drain and finish.
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE * 4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
